/* rtl/tsg_pkg.sv */
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared constants, codes and types of the touch strip gesture recogniser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

  localparam int ELECTRODES_DEF = 9;
  localparam int HOLD_DEPTH_DEF = 100;
  localparam int WINDOW_DEF     = 10;

  localparam int MASK_W = 9;
  localparam int GEST_W = 2;

  localparam logic [GEST_W-1:0] GEST_NONE = 2'd0;
  localparam logic [GEST_W-1:0] GEST_UP   = 2'd1;
  localparam logic [GEST_W-1:0] GEST_DOWN = 2'd2;
  localparam logic [GEST_W-1:0] GEST_TAP  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOLD,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_DEC,
    ST_FIN
  } tsg_state_t;

  typedef struct packed {
    logic sample;
    logic walk;
    logic mul;
    logic dec;
  } tsg_ctrl_t;

endpackage

`default_nettype wire

/* rtl/touch_strip_gesture_recognizer.sv */
// ----------------------------------------------------------------------------
// touch_strip_gesture_recognizer
// Turns a stream of electrode touch masks into slide, tap and hold gestures.
// ----------------------------------------------------------------------------
// One result beat leaves for every mask beat taken. When hold is clear, the
// time from one acceptance to the next is set by the walk over the centroid
// and gesture rings, whose RAMs give one entry each per cycle; a mask seen
// with hold set skips the walk. The next mask is accepted while a result
// waits in the output register; the block stalls only if a second result is
// ready before the first is taken. Mask bits at and above ELECTRODES are
// ignored.
`timescale 1ns / 1ps
`default_nettype none

module touch_strip_gesture_recognizer #(
  parameter int ELECTRODES = tsg_pkg::ELECTRODES_DEF,
  parameter int HOLD_DEPTH = tsg_pkg::HOLD_DEPTH_DEF,
  parameter int WINDOW     = tsg_pkg::WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tsg_pkg::MASK_W-1:0]  in_touch_mask,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tsg_pkg::GEST_W-1:0]       out_gesture,
  output logic                             out_hold_active
);

  tsg_pkg::tsg_state_t state_r, state_nxt;
  tsg_pkg::tsg_ctrl_t  ctrl;

  logic [ELECTRODES-1:0]       mask_e;
  logic                        hold;
  logic                        walk_last;
  logic [tsg_pkg::GEST_W-1:0]  gest;
  logic                        slot_free;
  logic                        load;
  logic                        out_valid_r;
  logic [tsg_pkg::GEST_W-1:0]  out_gesture_r;
  logic                        out_hold_r;

  for (genvar e = 0; e < ELECTRODES; e++) begin : g_mask
    if (e < tsg_pkg::MASK_W) begin : g_in
      assign mask_e[e] = in_touch_mask[e];
    end else begin : g_zero
      assign mask_e[e] = 1'b0;
    end
  end

  tsg_hold #(.ELECTRODES(ELECTRODES), .HOLD_DEPTH(HOLD_DEPTH)) u_hold (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (ctrl.sample),
    .mask   (mask_e),
    .hold   (hold)
  );

  tsg_window #(.ELECTRODES(ELECTRODES), .WINDOW(WINDOW)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .mask      (mask_e),
    .walk_last (walk_last),
    .gest      (gest)
  );

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsg_pkg::ST_IDLE:  if (in_valid) state_nxt = tsg_pkg::ST_HOLD;
      tsg_pkg::ST_HOLD:  state_nxt = hold ? tsg_pkg::ST_FIN : tsg_pkg::ST_WALK;
      tsg_pkg::ST_WALK:  if (walk_last) state_nxt = tsg_pkg::ST_DRAIN;
      tsg_pkg::ST_DRAIN: state_nxt = tsg_pkg::ST_MUL;
      tsg_pkg::ST_MUL:   state_nxt = tsg_pkg::ST_DEC;
      tsg_pkg::ST_DEC:   state_nxt = tsg_pkg::ST_FIN;
      tsg_pkg::ST_FIN:   if (slot_free) state_nxt = tsg_pkg::ST_IDLE;
      default:           state_nxt = tsg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl        = '0;
    load        = 1'b0;
    case (state_r)
      tsg_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctrl.sample = in_valid;
      end
      tsg_pkg::ST_WALK: ctrl.walk = 1'b1;
      tsg_pkg::ST_MUL:  ctrl.mul  = 1'b1;
      tsg_pkg::ST_DEC:  ctrl.dec  = 1'b1;
      tsg_pkg::ST_FIN:  load      = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_gesture_r <= hold ? tsg_pkg::GEST_NONE : gest;
      out_hold_r    <= hold;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gesture     = out_gesture_r;
  assign out_hold_active = out_hold_r;

endmodule

`default_nettype wire

/* rtl/tsg_ram.sv */
// ----------------------------------------------------------------------------
// tsg_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/tsg_hold.sv */
// ----------------------------------------------------------------------------
// tsg_hold
// Per-electrode touch run lengths and the hold flag, sampled every second tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsg_hold #(
  parameter int ELECTRODES = tsg_pkg::ELECTRODES_DEF,
  parameter int HOLD_DEPTH = tsg_pkg::HOLD_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  sample,
  input  wire logic [ELECTRODES-1:0] mask,
  output logic                       hold
);

  localparam int RL_W = $clog2(HOLD_DEPTH + 1);
  localparam logic [RL_W-1:0] HD_V = RL_W'(HOLD_DEPTH);

  logic [RL_W-1:0] run_r   [ELECTRODES];
  logic [RL_W-1:0] run_nxt [ELECTRODES];
  logic            phase_r;
  logic            hold_r;
  logic            any_nxt;

  always_comb begin
    any_nxt = 1'b0;
    for (int e = 0; e < ELECTRODES; e++) begin
      if (mask[e]) begin
        run_nxt[e] = (run_r[e] < HD_V) ? run_r[e] + RL_W'(1) : run_r[e];
      end else begin
        run_nxt[e] = '0;
      end
      if (run_nxt[e] >= HD_V) begin
        any_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b1;
      hold_r  <= 1'b1;
      for (int e = 0; e < ELECTRODES; e++) begin
        run_r[e] <= '0;
      end
    end else if (sample) begin
      phase_r <= !phase_r;
      if (phase_r) begin
        hold_r <= any_nxt;
        for (int e = 0; e < ELECTRODES; e++) begin
          run_r[e] <= run_nxt[e];
        end
      end
    end
  end

  assign hold = hold_r;

endmodule

`default_nettype wire

/* rtl/tsg_window.sv */
// ----------------------------------------------------------------------------
// tsg_window
// Centroid and gesture rings in RAM: walk, compare, vote and write back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsg_window #(
  parameter int ELECTRODES = tsg_pkg::ELECTRODES_DEF,
  parameter int WINDOW     = tsg_pkg::WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tsg_pkg::tsg_ctrl_t          ctrl,
  input  wire logic [ELECTRODES-1:0]       mask,
  output logic                             walk_last,
  output logic [tsg_pkg::GEST_W-1:0]       gest
);

  localparam int SUM_W = $clog2(ELECTRODES * (ELECTRODES - 1) / 2 + 1);
  localparam int CNT_W = $clog2(ELECTRODES + 1);
  localparam int CW    = SUM_W + CNT_W;
  localparam int PW    = SUM_W + CNT_W;
  localparam int AW    = $clog2(WINDOW);
  localparam int VC_W  = $clog2(WINDOW + 1);
  localparam int GW    = tsg_pkg::GEST_W;
  localparam logic [AW:0]   W_V  = (AW + 1)'(WINDOW);
  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

  logic [AW-1:0]    cptr_r, hptr_r, idx_r;
  logic             cval_r [WINDOW];
  logic             hval_r [WINDOW];
  logic             rd_on_r, rd_first_r, rd_cv_r, rd_hv_r;
  logic [SUM_W-1:0] nsum_r, osum_r, nsum_nxt;
  logic [CNT_W-1:0] ncnt_r, ocnt_r, ncnt_nxt;
  logic             tap0_r, empty_r;
  logic [VC_W-1:0]  cnt0_r, cnt1_r, cnt2_r;
  logic [PW-1:0]    pa_r, pb_r;
  logic [GW-1:0]    gest_r;

  logic [AW:0]      csum, hsum;
  logic [AW-1:0]    raddr_c, raddr_h;
  logic [CW-1:0]    c_q;
  logic [GW-1:0]    h_q;
  logic [SUM_W-1:0] e_sum;
  logic [CNT_W-1:0] e_cnt;
  logic [GW-1:0]    e_h;

  logic             empty_all, is_tap;
  logic [GW-1:0]    dir, vote_g;
  logic [VC_W-1:0]  v0, v1, v2, best;
  logic [GW-1:0]    lead;

  // ring addresses: oldest entry first
  always_comb begin
    csum    = {1'b0, cptr_r} + {1'b0, idx_r};
    hsum    = {1'b0, hptr_r} + {1'b0, idx_r};
    raddr_c = (csum >= W_V) ? AW'(csum - W_V) : AW'(csum);
    raddr_h = (hsum >= W_V) ? AW'(hsum - W_V) : AW'(hsum);
  end

  assign walk_last = (idx_r == LAST);

  tsg_ram #(.WIDTH(CW), .DEPTH(WINDOW)) u_cent_ram (
    .clk   (clk),
    .we    (ctrl.dec),
    .waddr (cptr_r),
    .wdata ({nsum_r, ncnt_r}),
    .raddr (raddr_c),
    .rdata (c_q)
  );

  tsg_ram #(.WIDTH(GW), .DEPTH(WINDOW)) u_gest_ram (
    .clk   (clk),
    .we    (ctrl.dec && !is_tap),
    .waddr (hptr_r),
    .wdata (dir),
    .raddr (raddr_h),
    .rdata (h_q)
  );

  // never-written entries read as their reset value
  always_comb begin
    e_sum = rd_cv_r ? c_q[CW-1:CNT_W] : '0;
    e_cnt = rd_cv_r ? c_q[CNT_W-1:0] : CNT_W'(1);
    e_h   = rd_hv_r ? h_q : tsg_pkg::GEST_NONE;
  end

  always_comb begin
    nsum_nxt = '0;
    ncnt_nxt = '0;
    for (int e = 0; e < ELECTRODES; e++) begin
      if (mask[e]) begin
        nsum_nxt = nsum_nxt + SUM_W'(e);
        ncnt_nxt = ncnt_nxt + CNT_W'(1);
      end
    end
  end

  // decision and majority vote
  always_comb begin
    empty_all = empty_r || (ncnt_r == '0);
    if (empty_all) begin
      dir = tsg_pkg::GEST_NONE;
    end else if (pa_r > pb_r) begin
      dir = tsg_pkg::GEST_UP;
    end else if (pa_r < pb_r) begin
      dir = tsg_pkg::GEST_DOWN;
    end else begin
      dir = tsg_pkg::GEST_NONE;
    end
    is_tap = (dir == tsg_pkg::GEST_NONE) && tap0_r;
    v0 = cnt0_r + VC_W'(dir == tsg_pkg::GEST_NONE);
    v1 = cnt1_r + VC_W'(dir == tsg_pkg::GEST_UP);
    v2 = cnt2_r + VC_W'(dir == tsg_pkg::GEST_DOWN);
    if (v0 < v1) begin
      lead = tsg_pkg::GEST_UP;
      best = v1;
    end else begin
      lead = tsg_pkg::GEST_NONE;
      best = v0;
    end
    vote_g = (best < v2) ? tsg_pkg::GEST_DOWN : lead;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cptr_r  <= '0;
      hptr_r  <= '0;
      idx_r   <= '0;
      rd_on_r <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        cval_r[i] <= 1'b0;
        hval_r[i] <= 1'b0;
      end
    end else begin
      rd_on_r <= ctrl.walk;
      if (ctrl.sample) begin
        idx_r <= '0;
      end else if (ctrl.walk) begin
        idx_r <= (idx_r == LAST) ? '0 : idx_r + AW'(1);
      end
      if (ctrl.dec) begin
        cval_r[cptr_r] <= 1'b1;
        cptr_r         <= (cptr_r == LAST) ? '0 : cptr_r + AW'(1);
        if (!is_tap) begin
          hval_r[hptr_r] <= 1'b1;
          hptr_r         <= (hptr_r == LAST) ? '0 : hptr_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= (idx_r == '0);
    rd_cv_r    <= cval_r[raddr_c];
    rd_hv_r    <= hval_r[raddr_h];
    if (ctrl.sample) begin
      nsum_r  <= nsum_nxt;
      ncnt_r  <= ncnt_nxt;
      tap0_r  <= mask[0];
      empty_r <= 1'b0;
      cnt0_r  <= '0;
      cnt1_r  <= '0;
      cnt2_r  <= '0;
    end else if (rd_on_r) begin
      if (e_cnt == '0) begin
        empty_r <= 1'b1;
      end
      if (rd_first_r) begin
        osum_r <= e_sum;
        ocnt_r <= e_cnt;
      end else begin
        case (e_h)
          tsg_pkg::GEST_NONE: cnt0_r <= cnt0_r + VC_W'(1);
          tsg_pkg::GEST_UP:   cnt1_r <= cnt1_r + VC_W'(1);
          tsg_pkg::GEST_DOWN: cnt2_r <= cnt2_r + VC_W'(1);
          default: ;
        endcase
      end
    end
    if (ctrl.mul) begin
      pa_r <= PW'(nsum_r) * PW'(ocnt_r);
      pb_r <= PW'(osum_r) * PW'(ncnt_r);
    end
    if (ctrl.dec) begin
      gest_r <= is_tap ? tsg_pkg::GEST_TAP : vote_g;
    end
  end

  assign gest = gest_r;

endmodule

`default_nettype wire

/* rtl/tsg_checker.sv */
// ----------------------------------------------------------------------------
// tsg_checker
// Port-level checks of the gesture recogniser, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsg_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [tsg_pkg::GEST_W-1:0] out_gesture,
  input wire logic                       out_hold_active
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_gesture) && $stable(out_hold_active))
    else $error("stalled result beat changed");

  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold_active |-> out_gesture == tsg_pkg::GEST_NONE)
    else $error("gesture reported while hold active");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("mask beat taken while previous still in work");

endmodule

bind touch_strip_gesture_recognizer tsg_checker u_tsg_checker (.*);

`default_nettype wire

/* tb/touch_strip_gesture_recognizer_test.sv */
// ----------------------------------------------------------------------------
// touch_strip_gesture_recognizer_test
// Self-checking regression for the touch strip gesture recogniser.
// ----------------------------------------------------------------------------
// A short table of touch masks comes first, with hand-read results for the
// opening rows after reset. It is followed by randomised touch sequences:
// slides up and down the strip, taps, empty gaps, noise and long holds. A
// behavioural gesture predictor in this file works out each result when its
// mask beat is accepted, and a monitor compares every result beat with the
// oldest prediction. Both channels idle at random in the first two of three
// phases, and the sender drains the block fully between phases.
`timescale 1ns / 1ps

module touch_strip_gesture_recognizer_test;

  localparam int N_EL   = tsg_pkg::ELECTRODES_DEF;
  localparam int HOLD_N = tsg_pkg::HOLD_DEPTH_DEF;
  localparam int WIN    = tsg_pkg::WINDOW_DEF;
  localparam int ROWS   = 25;
  localparam int PHASE_ITEMS = 500;

  typedef struct packed {
    logic [tsg_pkg::GEST_W-1:0] gesture;
    logic                       hold;
  } result_t;

  typedef struct packed {
    logic [tsg_pkg::MASK_W-1:0] mask;
    logic                       typed;
    logic [tsg_pkg::GEST_W-1:0] gesture;
    logic                       hold;
  } row_t;

  typedef enum int {SEQ_UP, SEQ_DOWN, SEQ_TAP, SEQ_GAP, SEQ_NOISE, SEQ_HOLD} seq_kind_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [tsg_pkg::MASK_W-1:0] in_touch_mask = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [tsg_pkg::GEST_W-1:0] out_gesture;
  logic                       out_hold_active;

  touch_strip_gesture_recognizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_touch_mask   (in_touch_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_gesture     (out_gesture),
    .out_hold_active (out_hold_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic       sample_now;
  logic       hold_set;
  logic [6:0] touch_run [N_EL];
  logic [5:0] ring_sum [WIN];
  logic [3:0] ring_cnt [WIN];
  logic [1:0] ring_gest [WIN];

  result_t gesture_q [$];
  result_t due_res;
  int      mismatch_count = 0;
  int      sent_count = 0;
  int      in_idle_pct = 0;
  int      out_idle_pct = 0;

  row_t directed_rows [ROWS] = '{
    {9'h000, 1'b1, tsg_pkg::GEST_NONE, 1'b0},
    {9'h001, 1'b1, tsg_pkg::GEST_TAP,  1'b0},
    {9'h1ff, 1'b1, tsg_pkg::GEST_TAP,  1'b0},
    {9'h100, 1'b1, tsg_pkg::GEST_NONE, 1'b0},
    {9'h001, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h002, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h004, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h008, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h010, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h020, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h040, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h080, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h100, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h180, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h0c0, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h060, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h030, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h018, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h00c, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h006, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h003, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h001, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h000, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h1ff, 1'b0, tsg_pkg::GEST_NONE, 1'b0},
    {9'h155, 1'b0, tsg_pkg::GEST_NONE, 1'b0}
  };

  function automatic void clear_gesture_state();
    sample_now = 1'b1;
    hold_set   = 1'b1;
    for (int e = 0; e < N_EL; e++) touch_run[e] = '0;
    for (int i = 0; i < WIN; i++) begin
      ring_sum[i]  = '0;
      ring_cnt[i]  = 4'd1;
      ring_gest[i] = tsg_pkg::GEST_NONE;
    end
  endfunction

  function automatic result_t predict_gesture(input logic [tsg_pkg::MASK_W-1:0] raw);
    logic [tsg_pkg::MASK_W-1:0] m;
    logic                       any_held;
    logic                       blank;
    logic [tsg_pkg::GEST_W-1:0] dir;
    logic [tsg_pkg::GEST_W-1:0] lead;
    logic [tsg_pkg::GEST_W-1:0] g;
    int                         nsum;
    int                         ncnt;
    int                         osum;
    int                         ocnt;
    int                         best;
    int                         votes [4];
    result_t                    r;
    m = raw & tsg_pkg::MASK_W'((1 << N_EL) - 1);
    if (sample_now) begin
      any_held = 1'b0;
      for (int e = 0; e < N_EL; e++) begin
        if (m[e]) begin
          if (touch_run[e] < HOLD_N) touch_run[e] = touch_run[e] + 7'd1;
        end else begin
          touch_run[e] = '0;
        end
        if (touch_run[e] >= HOLD_N) any_held = 1'b1;
      end
      hold_set = any_held;
    end
    sample_now = !sample_now;
    g = tsg_pkg::GEST_NONE;
    if (!hold_set) begin
      nsum = 0;
      ncnt = 0;
      for (int e = 0; e < N_EL; e++) begin
        if (m[e]) begin
          nsum += e;
          ncnt++;
        end
      end
      blank = (ncnt == 0);
      for (int i = 0; i < WIN; i++) if (ring_cnt[i] == 0) blank = 1'b1;
      osum = int'(ring_sum[0]);
      ocnt = int'(ring_cnt[0]);
      for (int i = 1; i < WIN; i++) begin
        ring_sum[i-1] = ring_sum[i];
        ring_cnt[i-1] = ring_cnt[i];
      end
      ring_sum[WIN-1] = nsum[5:0];
      ring_cnt[WIN-1] = ncnt[3:0];
      dir = tsg_pkg::GEST_NONE;
      if (!blank) begin
        if (nsum * ocnt > osum * ncnt) dir = tsg_pkg::GEST_UP;
        else if (nsum * ocnt < osum * ncnt) dir = tsg_pkg::GEST_DOWN;
      end
      if (dir == tsg_pkg::GEST_NONE && m[0]) begin
        g = tsg_pkg::GEST_TAP;
      end else begin
        for (int k = 0; k < 4; k++) votes[k] = 0;
        for (int i = 1; i < WIN; i++) begin
          ring_gest[i-1] = ring_gest[i];
          votes[ring_gest[i]]++;
        end
        votes[dir]++;
        ring_gest[WIN-1] = dir;
        lead = tsg_pkg::GEST_NONE;
        best = votes[tsg_pkg::GEST_NONE];
        if (best < votes[tsg_pkg::GEST_UP]) begin
          lead = tsg_pkg::GEST_UP;
          best = votes[tsg_pkg::GEST_UP];
        end
        g = (best < votes[tsg_pkg::GEST_DOWN]) ? tsg_pkg::GEST_DOWN : lead;
      end
    end
    r.gesture = g;
    r.hold    = hold_set;
    return r;
  endfunction

  task automatic send_mask(input logic [tsg_pkg::MASK_W-1:0] m, input logic typed,
                           input result_t typed_res);
    result_t r;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_touch_mask <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_gesture(m);
    gesture_q.push_back(typed ? typed_res : r);
    sent_count++;
  endtask

  task automatic play_slide(input bit rising);
    int w;
    int top;
    int pos;
    int steps;
    int dwell;
    logic [tsg_pkg::MASK_W-1:0] m;
    w     = $urandom_range(1, 3);
    top   = N_EL - w;
    pos   = rising ? $urandom_range(0, top / 2) : $urandom_range(top / 2, top);
    steps = $urandom_range(4, 14);
    dwell = $urandom_range(1, 2);
    for (int s = 0; s < steps; s++) begin
      m = tsg_pkg::MASK_W'(((1 << w) - 1) << pos);
      if ($urandom_range(0, 7) == 0)
        m = m ^ (9'h001 << $urandom_range(0, tsg_pkg::MASK_W - 1));
      send_mask(m, 1'b0, '0);
      if ((s + 1) % dwell == 0) begin
        if (rising && pos < top) pos++;
        else if (!rising && pos > 0) pos--;
      end
    end
  endtask

  task automatic play_tap();
    int n;
    logic [tsg_pkg::MASK_W-1:0] m;
    if ($urandom_range(0, 1) == 1) send_mask('0, 1'b0, '0);
    m = 9'h001 | (($urandom_range(0, 3) == 0) ? 9'h002 : 9'h000);
    n = $urandom_range(3, 12);
    repeat (n) send_mask(m, 1'b0, '0);
  endtask

  task automatic play_hold();
    int e;
    int n;
    logic [tsg_pkg::MASK_W-1:0] m;
    e = $urandom_range(0, N_EL - 1);
    n = $urandom_range(205, 260);
    repeat (n) begin
      m = 9'h001 << e;
      if ($urandom_range(0, 3) == 0) m = m | tsg_pkg::MASK_W'($urandom_range(0, 511));
      send_mask(m, 1'b0, '0);
    end
  endtask

  task automatic play_sequence(input seq_kind_t kind);
    int n;
    case (kind)
      SEQ_UP:   play_slide(1'b1);
      SEQ_DOWN: play_slide(1'b0);
      SEQ_TAP:  play_tap();
      SEQ_HOLD: play_hold();
      SEQ_GAP: begin
        n = $urandom_range(1, 3);
        repeat (n) send_mask('0, 1'b0, '0);
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) send_mask(tsg_pkg::MASK_W'($urandom_range(0, 511)), 1'b0, '0);
      end
    endcase
  endtask

  function automatic seq_kind_t pick_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return SEQ_HOLD;
    if (r <= 30) return SEQ_UP;
    if (r <= 60) return SEQ_DOWN;
    if (r <= 75) return SEQ_TAP;
    if (r <= 85) return SEQ_GAP;
    return SEQ_NOISE;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (gesture_q.size() == 0) begin
        $error("unexpected result beat: gesture %0d, hold_active %0d",
               out_gesture, out_hold_active);
        mismatch_count++;
      end else begin
        due_res = gesture_q.pop_front();
        if (out_gesture !== due_res.gesture) begin
          $error("gesture: expected %0d, actual %0d", due_res.gesture, out_gesture);
          mismatch_count++;
        end
        if (out_hold_active !== due_res.hold) begin
          $error("hold_active: expected %0d, actual %0d", due_res.hold, out_hold_active);
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  initial begin
    in_idle_pct  = 11;
    out_idle_pct = 78;
    clear_gesture_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < ROWS; i++) begin
      send_mask(directed_rows[i].mask, directed_rows[i].typed,
                {directed_rows[i].gesture, directed_rows[i].hold});
    end
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 11;
          out_idle_pct = 78;
        end
        1: begin
          in_idle_pct  = 78;
          out_idle_pct = 11;
          play_hold();
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      while (sent_count < ROWS + (phase + 1) * PHASE_ITEMS) play_sequence(pick_sequence());
      drain_results();
    end
    repeat (4 * (WIN + 6)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("touch_strip_gesture_recognizer regression: pass");
    end else begin
      $display("touch_strip_gesture_recognizer regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("touch_strip_gesture_recognizer regression: fail");
    $finish;
  end

endmodule

/* touch_strip_gesture_recognizer.f */
rtl/tsg_pkg.sv
rtl/tsg_ram.sv
rtl/tsg_hold.sv
rtl/tsg_window.sv
rtl/touch_strip_gesture_recognizer.sv
rtl/tsg_checker.sv
tb/touch_strip_gesture_recognizer_test.sv
